FILE: sv/ppm_frame_decoder_unit_defines.svh
// Assertion macros shared by the decoder modules.
`ifndef PPM_FRAME_DECODER_UNIT_DEFINES_SVH
`define PPM_FRAME_DECODER_UNIT_DEFINES_SVH

// Condition a implies condition b in the same cycle.
`define PPMFD_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("ppmfd: implication check failed");

// Condition a implies condition b in the following cycle.
`define PPMFD_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("ppmfd: next-cycle check failed");

// Condition a never holds.
`define PPMFD_ASSERT_NEVER(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(a)) \
		else $error("ppmfd: forbidden condition seen");

`endif

FILE: sv/ppmfd_pkg.sv
package ppmfd_pkg;

	// Channel count and derived widths
	localparam int unsigned NUM_CHANNELS = 8;
	localparam int unsigned OUT_CHANNELS = 8;
	localparam int unsigned CHAN_W       = 16;
	localparam int unsigned SLOT_W       = $clog2(NUM_CHANNELS + 1);
	localparam int unsigned CFG_IDX_W    = 3;

	// Event codes
	localparam logic [1:0] CMD_CAPTURE         = 2'd0;
	localparam logic [1:0] CMD_TIMEOUT         = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT_CAPTURE = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_FLOOR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_VALUE = 3'd4;

	// Register reset values
	localparam logic [CHAN_W-1:0] RST_SYNC_THRESHOLD = 16'd3000;
	localparam logic [CHAN_W-1:0] RST_WINDOW_LOW     = 16'd500;
	localparam logic [CHAN_W-1:0] RST_WINDOW_HIGH    = 16'd2500;
	localparam logic [CHAN_W-1:0] RST_VALUE_FLOOR    = 16'd1000;
	localparam logic [CHAN_W-1:0] RST_FAILSAFE_VALUE = 16'd1500;

	typedef struct packed {
		logic [CHAN_W-1:0] sync_threshold;
		logic [CHAN_W-1:0] window_low;
		logic [CHAN_W-1:0] window_high;
		logic [CHAN_W-1:0] value_floor;
		logic [CHAN_W-1:0] failsafe_value;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [CHAN_W-1:0] interval;
	} item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan0;
		logic [CHAN_W-1:0] chan1;
		logic [CHAN_W-1:0] chan2;
		logic [CHAN_W-1:0] chan3;
		logic [CHAN_W-1:0] chan4;
		logic [CHAN_W-1:0] chan5;
		logic [CHAN_W-1:0] chan6;
		logic [CHAN_W-1:0] chan7;
		logic [3:0]        slot;
		logic              signal_seen;
	} result_t;

	typedef logic [NUM_CHANNELS-1:0][CHAN_W-1:0] store_t;

endpackage

FILE: sv/ppmfd_cfg_regs.sv
module ppmfd_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ppmfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ppmfd_pkg::CHAN_W-1:0]       cfg_wdata,
	output ppmfd_pkg::cfg_t                    cfg
);

	ppmfd_pkg::cfg_t cfg_q;

	// Write the addressed register; ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_threshold <= ppmfd_pkg::RST_SYNC_THRESHOLD;
			cfg_q.window_low     <= ppmfd_pkg::RST_WINDOW_LOW;
			cfg_q.window_high    <= ppmfd_pkg::RST_WINDOW_HIGH;
			cfg_q.value_floor    <= ppmfd_pkg::RST_VALUE_FLOOR;
			cfg_q.failsafe_value <= ppmfd_pkg::RST_FAILSAFE_VALUE;
		end else if (cfg_we) begin
			case (cfg_index)
				ppmfd_pkg::REG_SYNC_THRESHOLD: cfg_q.sync_threshold <= cfg_wdata;
				ppmfd_pkg::REG_WINDOW_LOW:     cfg_q.window_low     <= cfg_wdata;
				ppmfd_pkg::REG_WINDOW_HIGH:    cfg_q.window_high    <= cfg_wdata;
				ppmfd_pkg::REG_VALUE_FLOOR:    cfg_q.value_floor    <= cfg_wdata;
				ppmfd_pkg::REG_FAILSAFE_VALUE: cfg_q.failsafe_value <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/ppmfd_decode_core.sv
`include "ppm_frame_decoder_unit_defines.svh"

module ppmfd_decode_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppmfd_pkg::cfg_t      cfg,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  ppmfd_pkg::item_t     item,
	input  logic                 push_ready,
	output logic                 push_valid,
	output ppmfd_pkg::result_t   push_data
);

	logic                                  valid_s1;
	ppmfd_pkg::item_t                      item_s1;
	ppmfd_pkg::store_t                     store_q;
	logic [ppmfd_pkg::SLOT_W-1:0]          slot_q;
	logic                                  seen_q;

	ppmfd_pkg::store_t                     store_d;
	logic [ppmfd_pkg::SLOT_W-1:0]          slot_d;
	logic                                  seen_d;
	logic                                  advance;

	function automatic logic [ppmfd_pkg::CHAN_W-1:0] chan_of(ppmfd_pkg::store_t s,
			int unsigned i);
		logic [ppmfd_pkg::CHAN_W-1:0] r;
		r = '0;
		for (int unsigned j = 0; j < ppmfd_pkg::NUM_CHANNELS; j++) begin
			if (j == i) r = s[j];
		end
		return r;
	endfunction

	// Input register: refill when empty or whenever the held transaction moves on
	assign advance    = valid_s1 && push_ready;
	assign item_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// Apply the timeout, then the capture, to the decoder state
	always_comb begin
		logic                          do_to;
		logic                          do_cap;
		logic                          in_win;
		logic [ppmfd_pkg::CHAN_W:0]    sum;
		logic [ppmfd_pkg::CHAN_W-1:0]  val;
		do_to  = (item_s1.cmd == ppmfd_pkg::CMD_TIMEOUT) ||
			(item_s1.cmd == ppmfd_pkg::CMD_TIMEOUT_CAPTURE);
		do_cap = (item_s1.cmd == ppmfd_pkg::CMD_CAPTURE) ||
			(item_s1.cmd == ppmfd_pkg::CMD_TIMEOUT_CAPTURE);
		in_win = (item_s1.interval > cfg.window_low) && (item_s1.interval < cfg.window_high);
		sum    = {1'b0, item_s1.interval} + {{ppmfd_pkg::CHAN_W{1'b0}}, 1'b1};
		val    = (sum[ppmfd_pkg::CHAN_W-1:0] < cfg.value_floor) ? cfg.value_floor :
			sum[ppmfd_pkg::CHAN_W-1:0];

		store_d = store_q;
		slot_d  = slot_q;
		seen_d  = seen_q;

		// Timeout: drop the frame, fall back to failsafe if nothing was seen
		if (do_to) begin
			slot_d = '0;
			if (!seen_q) begin
				for (int unsigned j = 0; j < ppmfd_pkg::NUM_CHANNELS; j++) begin
					store_d[j] = cfg.failsafe_value;
				end
			end
		end

		// Capture: store a windowed interval or abort the frame
		if (do_cap && (slot_d != '0)) begin
			if (in_win) begin
				for (int unsigned j = 0; j < ppmfd_pkg::NUM_CHANNELS; j++) begin
					if (slot_d == ppmfd_pkg::SLOT_W'(j + 1)) store_d[j] = val;
				end
				seen_d = 1'b1;
				if (slot_d < ppmfd_pkg::SLOT_W'(ppmfd_pkg::NUM_CHANNELS)) begin
					slot_d = slot_d + ppmfd_pkg::SLOT_W'(1);
				end else begin
					slot_d = '0;
				end
			end else begin
				slot_d = '0;
			end
		end

		// Sync gap opens a new frame
		if (do_cap && (slot_d == '0) && (item_s1.interval > cfg.sync_threshold)) begin
			slot_d = ppmfd_pkg::SLOT_W'(1);
		end
	end

	// Commit the state as the transaction leaves for the result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			slot_q  <= '0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			store_q <= store_d;
			slot_q  <= slot_d;
			seen_q  <= seen_d;
		end
	end

	// Report the state after the event
	always_comb begin
		push_data.chan0       = chan_of(store_d, 0);
		push_data.chan1       = chan_of(store_d, 1);
		push_data.chan2       = chan_of(store_d, 2);
		push_data.chan3       = chan_of(store_d, 3);
		push_data.chan4       = chan_of(store_d, 4);
		push_data.chan5       = chan_of(store_d, 5);
		push_data.chan6       = chan_of(store_d, 6);
		push_data.chan7       = chan_of(store_d, 7);
		push_data.slot        = 4'(slot_d);
		push_data.signal_seen = seen_d;
	end

	`PPMFD_ASSERT_NEXT(a_seen_sticky, clk, arst_n, seen_q, seen_q)
	`PPMFD_ASSERT_NEVER(a_slot_range, clk, arst_n,
		slot_q > ppmfd_pkg::SLOT_W'(ppmfd_pkg::NUM_CHANNELS))
	`PPMFD_ASSERT_NEXT(a_timeout_clears, clk, arst_n,
		advance && (item_s1.cmd == ppmfd_pkg::CMD_TIMEOUT), slot_q == '0)

endmodule

FILE: sv/ppmfd_out_buffer.sv
`include "ppm_frame_decoder_unit_defines.svh"

module ppmfd_out_buffer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  ppmfd_pkg::result_t   push_data,
	output logic                 result_valid,
	input  logic                 result_ready,
	output ppmfd_pkg::result_t   result
);

	logic                head_valid_q;
	logic                skid_valid_q;
	ppmfd_pkg::result_t  head_q;
	ppmfd_pkg::result_t  skid_q;
	logic                push;
	logic                pop;

	assign push_ready   = !skid_valid_q;
	assign push         = push_valid && push_ready;
	assign pop          = head_valid_q && result_ready;
	assign result_valid = head_valid_q;
	assign result       = head_q;

	// Track occupancy of head and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) skid_valid_q <= 1'b0;
			end else if (push && head_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			if (pop) begin
				head_valid_q <= skid_valid_q || push;
			end else if (push) begin
				head_valid_q <= 1'b1;
			end
		end
	end

	// Move payloads: refill head from skid first, else from the new transaction
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) head_q <= skid_q;
		end else if (push) begin
			if (!head_valid_q || pop) begin
				head_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	`PPMFD_ASSERT_IMPLY(a_skid_needs_head, clk, arst_n, skid_valid_q, head_valid_q)
	`PPMFD_ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_valid_q && pop, !skid_valid_q)

endmodule

FILE: sv/ppm_frame_decoder_unit.sv
// Channel   Handshake                     Payload
// item      item_valid / item_ready       ppmfd_pkg::item_t   (cmd, interval)
// result    result_valid / result_ready   ppmfd_pkg::result_t (chan0..chan7, slot, signal_seen)
// cfg       cfg_we (no wait)              cfg_index, cfg_wdata
//
// One event per clock sustained while result_ready stays high; each item passes the input
// register and then the result register before its result is presented.
// Decoder state advances as a transaction leaves the input register for the result buffer.
// A skid entry catches the transaction in flight when result_ready drops: item_ready falls
// the cycle after a result stall begins and rises again once the held result is taken.
// Reset is asynchronous: registers to defaults, channels zero, slot zero, flag clear.
module ppm_frame_decoder_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  ppmfd_pkg::item_t                   item,
	output logic                               result_valid,
	input  logic                               result_ready,
	output ppmfd_pkg::result_t                 result,
	input  logic                               cfg_we,
	input  logic [ppmfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ppmfd_pkg::CHAN_W-1:0]       cfg_wdata
);

	ppmfd_pkg::cfg_t     cfg;
	ppmfd_pkg::result_t  push_data;
	logic                push_valid;
	logic                push_ready;

	// Configuration registers
	ppmfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input register and frame decode
	ppmfd_decode_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	// Result register with skid entry
	ppmfd_out_buffer u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: verif/ppm_frame_decoder_unit_tb.sv
module ppm_frame_decoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Event code with no meaning to the decoder
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 4;
	localparam int CHAN_IDX_W   = $clog2(ppmfd_pkg::NUM_CHANNELS);

	logic                                clk          = 1'b0;
	logic                                arst_n       = 1'b0;
	logic                                item_valid   = 1'b0;
	logic                                item_ready;
	ppmfd_pkg::item_t                    item         = '0;
	logic                                result_valid;
	logic                                result_ready = 1'b0;
	ppmfd_pkg::result_t                  result;
	logic                                cfg_we       = 1'b0;
	logic [ppmfd_pkg::CFG_IDX_W-1:0]     cfg_index    = '0;
	logic [ppmfd_pkg::CHAN_W-1:0]        cfg_wdata    = '0;

	// Decoder shadow: registers, channel values, slot and signal flag
	ppmfd_pkg::cfg_t                     regs_model;
	logic [ppmfd_pkg::CHAN_W-1:0]        chan_model [ppmfd_pkg::NUM_CHANNELS];
	logic [ppmfd_pkg::SLOT_W-1:0]        slot_model;
	logic                                seen_model;

	ppmfd_pkg::item_t   pending_events[$];
	ppmfd_pkg::result_t expected_states[$];
	ppmfd_pkg::result_t oldest_state;

	int events_sent      = 0;
	int ignored_sent     = 0;
	int states_checked   = 0;
	int frames_completed = 0;
	int settings_used    = 0;
	int mismatches       = 0;
	int idle_cycles      = 0;
	int item_gap         = 0;
	int stall_left       = 0;
	bit item_busy        = 1'b0;
	bit item_idling      = 1'b0;
	bit result_idling    = 1'b0;

	ppm_frame_decoder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Advance the shadow decoder by one event and return the state it reports
	function automatic ppmfd_pkg::result_t decode_event(ppmfd_pkg::item_t ev);
		logic [16:0]           stored;
		logic [CHAN_IDX_W-1:0] idx;
		ppmfd_pkg::result_t    res;
		if (ev.cmd == ppmfd_pkg::CMD_TIMEOUT || ev.cmd == ppmfd_pkg::CMD_TIMEOUT_CAPTURE) begin
			slot_model = '0;
			if (!seen_model) begin
				for (int i = 0; i < ppmfd_pkg::NUM_CHANNELS; i++)
					chan_model[i] = regs_model.failsafe_value;
			end
		end
		if (ev.cmd == ppmfd_pkg::CMD_CAPTURE || ev.cmd == ppmfd_pkg::CMD_TIMEOUT_CAPTURE) begin
			if (slot_model != 0) begin
				if (ev.interval > regs_model.window_low &&
						ev.interval < regs_model.window_high) begin
					stored = {1'b0, ev.interval} + 17'd1;
					if (stored < regs_model.value_floor)
						stored = {1'b0, regs_model.value_floor};
					idx = CHAN_IDX_W'(slot_model - 1'b1);
					chan_model[idx] = stored[ppmfd_pkg::CHAN_W-1:0];
					if (slot_model < ppmfd_pkg::NUM_CHANNELS) begin
						slot_model = slot_model + 1'b1;
					end else begin
						slot_model = '0;
						frames_completed++;
					end
					seen_model = 1'b1;
				end else begin
					// out of window: abort the frame
					slot_model = '0;
				end
			end
			// the same interval may still open a frame
			if (slot_model == 0 && ev.interval > regs_model.sync_threshold)
				slot_model = ppmfd_pkg::SLOT_W'(1);
		end
		res.chan0       = chan_model[0];
		res.chan1       = chan_model[1];
		res.chan2       = chan_model[2];
		res.chan3       = chan_model[3];
		res.chan4       = chan_model[4];
		res.chan5       = chan_model[5];
		res.chan6       = chan_model[6];
		res.chan7       = chan_model[7];
		res.slot        = 4'(slot_model);
		res.signal_seen = seen_model;
		return res;
	endfunction

	function automatic void check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: mismatch in %s: expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	function automatic void queue_event(logic [1:0] cmd,
			logic [ppmfd_pkg::CHAN_W-1:0] interval);
		ppmfd_pkg::item_t ev;
		ev.cmd      = cmd;
		ev.interval = interval;
		pending_events.push_back(ev);
		if (cmd == CMD_NONE)
			ignored_sent++;
		else
			events_sent++;
	endfunction

	// Driver: record each accepted transaction and predict its result
	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready) begin
			expected_states.push_back(decode_event(item));
			item_busy = 1'b0;
			if (item_idling && $urandom_range(3, 0) == 0)
				item_gap = $urandom_range(11, 1);
		end
	end

	// Driver: present the next pending event, or idle
	always @(negedge clk) begin
		if (!item_busy) begin
			if (item_gap > 0) begin
				item_gap--;
				item_valid <= 1'b0;
			end else if (pending_events.size() != 0) begin
				item       <= pending_events.pop_front();
				item_valid <= 1'b1;
				item_busy  = 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall in bursts while idling is enabled
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (result_idling && $urandom_range(5, 0) == 0) begin
			stall_left = $urandom_range(10, 0);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Monitor: compare each result with the oldest predicted state
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_states.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %p", $time, result);
				mismatches++;
			end else begin
				oldest_state = expected_states.pop_front();
				check_field("chan0", oldest_state.chan0, result.chan0);
				check_field("chan1", oldest_state.chan1, result.chan1);
				check_field("chan2", oldest_state.chan2, result.chan2);
				check_field("chan3", oldest_state.chan3, result.chan3);
				check_field("chan4", oldest_state.chan4, result.chan4);
				check_field("chan5", oldest_state.chan5, result.chan5);
				check_field("chan6", oldest_state.chan6, result.chan6);
				check_field("chan7", oldest_state.chan7, result.chan7);
				check_field("slot", oldest_state.slot, result.slot);
				check_field("signal_seen", oldest_state.signal_seen, result.signal_seen);
				states_checked++;
			end
		end
	end

	// Watchdog: give up after too long without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("%0t: no transaction for %0d cycles, %0d results outstanding",
						$time, idle_cycles, expected_states.size());
					$display("ppm_frame_decoder_unit_tb failed");
					$finish;
				end
			end
		end
	end

	// Hold until every event is taken and every result has come back
	task automatic wait_idle();
		while (pending_events.size() != 0 || item_busy || expected_states.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [ppmfd_pkg::CFG_IDX_W-1:0] idx,
			logic [ppmfd_pkg::CHAN_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			ppmfd_pkg::REG_SYNC_THRESHOLD: regs_model.sync_threshold = value;
			ppmfd_pkg::REG_WINDOW_LOW:     regs_model.window_low     = value;
			ppmfd_pkg::REG_WINDOW_HIGH:    regs_model.window_high    = value;
			ppmfd_pkg::REG_VALUE_FLOOR:    regs_model.value_floor    = value;
			ppmfd_pkg::REG_FAILSAFE_VALUE: regs_model.failsafe_value = value;
			default: ;
		endcase
	endtask

	// Random traffic: mostly sync gaps followed by runs of channel intervals
	task automatic gen_traffic(int n);
		int counted;
		int pick;
		int run_len;
		int lo;
		int hi;
		int iv;
		bit open_window;
		counted     = 0;
		lo          = int'(regs_model.window_low) + 1;
		hi          = int'(regs_model.window_high) - 1;
		open_window = (hi >= lo);
		while (counted < n) begin
			pick = $urandom_range(99, 0);
			if (pick < 6) begin
				queue_event(CMD_NONE, ppmfd_pkg::CHAN_W'($urandom));
			end else if (pick < 14) begin
				queue_event(2'($urandom_range(2, 0)), ppmfd_pkg::CHAN_W'($urandom));
				counted++;
			end else if (pick < 19) begin
				queue_event(ppmfd_pkg::CMD_TIMEOUT, ppmfd_pkg::CHAN_W'($urandom));
				counted++;
			end else begin
				if (regs_model.sync_threshold < 16'hFFFF)
					iv = $urandom_range(65535, int'(regs_model.sync_threshold) + 1);
				else
					iv = $urandom;
				queue_event(($urandom_range(9, 0) == 0) ? ppmfd_pkg::CMD_TIMEOUT_CAPTURE :
					ppmfd_pkg::CMD_CAPTURE, ppmfd_pkg::CHAN_W'(iv));
				run_len = $urandom_range(ppmfd_pkg::NUM_CHANNELS + 1, 1);
				for (int k = 0; k < run_len; k++) begin
					if (!open_window || $urandom_range(11, 0) == 0) begin
						if ($urandom_range(1, 0) == 0)
							iv = $urandom_range(int'(regs_model.window_low), 0);
						else
							iv = $urandom_range(65535, int'(regs_model.window_high));
					end else begin
						iv = $urandom_range(hi, lo);
					end
					queue_event(ppmfd_pkg::CMD_CAPTURE, ppmfd_pkg::CHAN_W'(iv));
				end
				counted += run_len + 1;
			end
		end
	endtask

	// Reprogram all registers while idle, then run a batch of traffic
	task automatic run_setting(logic [ppmfd_pkg::CHAN_W-1:0] sync_thr,
			logic [ppmfd_pkg::CHAN_W-1:0] win_lo, logic [ppmfd_pkg::CHAN_W-1:0] win_hi,
			logic [ppmfd_pkg::CHAN_W-1:0] floor_val,
			logic [ppmfd_pkg::CHAN_W-1:0] fail_val, int n);
		wait_idle();
		write_reg(ppmfd_pkg::REG_SYNC_THRESHOLD, sync_thr);
		write_reg(ppmfd_pkg::REG_WINDOW_LOW, win_lo);
		write_reg(ppmfd_pkg::REG_WINDOW_HIGH, win_hi);
		write_reg(ppmfd_pkg::REG_VALUE_FLOOR, floor_val);
		write_reg(ppmfd_pkg::REG_FAILSAFE_VALUE, fail_val);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
		gen_traffic(n);
	endtask

	initial begin
		int wl;
		int wh;
		int sync_thr;
		regs_model.sync_threshold = ppmfd_pkg::RST_SYNC_THRESHOLD;
		regs_model.window_low     = ppmfd_pkg::RST_WINDOW_LOW;
		regs_model.window_high    = ppmfd_pkg::RST_WINDOW_HIGH;
		regs_model.value_floor    = ppmfd_pkg::RST_VALUE_FLOOR;
		regs_model.failsafe_value = ppmfd_pkg::RST_FAILSAFE_VALUE;
		for (int i = 0; i < ppmfd_pkg::NUM_CHANNELS; i++)
			chan_model[i] = '0;
		slot_model    = '0;
		seen_model    = 1'b0;
		settings_used = 1;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		item_idling   = 1'b1;
		result_idling = 1'b1;
		// timeout before any signal writes the failsafe value everywhere
		queue_event(ppmfd_pkg::CMD_TIMEOUT, 16'd0);
		queue_event(CMD_NONE, 16'hFFFF);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd0);
		// sync threshold is strict
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd3000);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'hFFFF);
		// window edges abort the frame
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd500);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd3001);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd2500);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd3001);
		queue_event(ppmfd_pkg::CMD_TIMEOUT, 16'd0);
		wait_idle();
		write_reg(ppmfd_pkg::REG_FAILSAFE_VALUE, 16'hFFFF);
		@(negedge clk);
		cfg_we <= 1'b0;
		// timeout applied before the capture that syncs
		queue_event(ppmfd_pkg::CMD_TIMEOUT_CAPTURE, 16'd4000);
		// full frame: floor raise, top of window, plain values
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd501);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd2499);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd999);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd1000);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd1500);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd1234);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd2000);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd777);
		// after the signal is seen a timeout keeps the channels
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd3001);
		queue_event(ppmfd_pkg::CMD_CAPTURE, 16'd1600);
		queue_event(ppmfd_pkg::CMD_TIMEOUT, 16'd0);
		queue_event(ppmfd_pkg::CMD_TIMEOUT_CAPTURE, 16'd1600);
		queue_event(CMD_NONE, 16'd0);

		// extremes: empty windows, every gap a sync or none at all
		run_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 30);
		run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20);
		// widest window with the highest floor
		run_setting(16'hFFFE, 16'd0, 16'hFFFF, 16'hFFFF, ppmfd_pkg::CHAN_W'($urandom), 30);
		// sync threshold inside the window
		run_setting(16'd1000, 16'd200, 16'd3000, 16'd0, ppmfd_pkg::CHAN_W'($urandom), 40);

		repeat (4) begin
			item_idling   = 1'($urandom_range(1, 0));
			result_idling = 1'($urandom_range(1, 0));
			wl = $urandom_range(2000, 0);
			wh = wl + $urandom_range(4000, 2);
			if ($urandom_range(3, 0) == 0)
				sync_thr = $urandom_range(wh, 0);
			else
				sync_thr = wh + $urandom_range(3000, 0);
			run_setting(ppmfd_pkg::CHAN_W'(sync_thr), ppmfd_pkg::CHAN_W'(wl),
				ppmfd_pkg::CHAN_W'(wh), ppmfd_pkg::CHAN_W'($urandom_range(3000, 0)),
				ppmfd_pkg::CHAN_W'($urandom), 60);
		end

		// closing stretch at reset values, no idling
		item_idling   = 1'b0;
		result_idling = 1'b0;
		run_setting(ppmfd_pkg::RST_SYNC_THRESHOLD, ppmfd_pkg::RST_WINDOW_LOW,
			ppmfd_pkg::RST_WINDOW_HIGH, ppmfd_pkg::RST_VALUE_FLOOR,
			ppmfd_pkg::RST_FAILSAFE_VALUE, 50);
		wait_idle();
		repeat (8) @(negedge clk);

		$display("drove %0d decoder events and %0d unused codes over %0d register settings",
			events_sent, ignored_sent, settings_used);
		$display("checked %0d reported states, %0d frames decoded to the last slot",
			states_checked, frames_completed);
		if (mismatches == 0)
			$display("ppm_frame_decoder_unit_tb passed");
		else
			$display("ppm_frame_decoder_unit_tb failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/ppmfd_pkg.sv
sv/ppmfd_cfg_regs.sv
sv/ppmfd_decode_core.sv
sv/ppmfd_out_buffer.sv
sv/ppm_frame_decoder_unit.sv
verif/ppm_frame_decoder_unit_tb.sv
